// File: sv/ermq12_pkg.sv
// ----------------------------------------------------------------------------
// ermq12_pkg
// Types and constants shared by the Euler-angle rotation matrix builder.
// ----------------------------------------------------------------------------
package ermq12_pkg;

  localparam int HALF_W  = 16;
  localparam int WORD_W  = 2 * HALF_W;
  localparam int PROD_W  = 32;
  localparam int ANGLE_W = 12;
  localparam int INDEX_W = 12;
  localparam int FIELD_W = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_BUILD = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [HALF_W-1:0]  entry_low;
    logic signed [HALF_W-1:0]  entry_high;
    logic [FIELD_W-1:0]        angle_first;
    logic [FIELD_W-1:0]        angle_second;
    logic [FIELD_W-1:0]        angle_third;
  } in_item_t;

  typedef struct packed {
    logic signed [HALF_W-1:0] m00;
    logic signed [HALF_W-1:0] m01;
    logic signed [HALF_W-1:0] m02;
    logic signed [HALF_W-1:0] m10;
    logic signed [HALF_W-1:0] m11;
    logic signed [HALF_W-1:0] m12;
    logic signed [HALF_W-1:0] m20;
    logic signed [HALF_W-1:0] m21;
    logic signed [HALF_W-1:0] m22;
  } out_item_t;

endpackage

// File: sv/euler_rotation_matrix_q12.sv
// throughput: one transaction per cycle while out_ready_i does not stall the pipeline, writes and builds mixed freely
// the table is held three times (one read port per angle); a write is seen
// by any build accepted in a later cycle
// reset clears the stage valid bits only; table contents stay undefined
// until written, so there is no clearing pass after reset
// ----------------------------------------------------------------------------
// euler_rotation_matrix_q12
// Four-stage pipeline: table lookup, first products, second products, sums.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_q12 #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ermq12_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ermq12_pkg::out_item_t out_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = AW + 4;
  localparam int HW = ermq12_pkg::HALF_W;
  localparam int WW = ermq12_pkg::WORD_W;
  localparam int PW = ermq12_pkg::PROD_W - FRACTION_BITS;

  // 12-bit index modulo the table depth, quotient is below 16
  function automatic logic [AW-1:0] fold_idx(input logic [ermq12_pkg::ANGLE_W-1:0] a);
    logic [RW-1:0] r;
    r = RW'(a);
    for (int k = 3; k >= 0; k--) begin
      if (r >= RW'(TABLE_DEPTH << k)) begin
        r = r - RW'(TABLE_DEPTH << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // stage enables, a bubble in any stage lets the stages before it move
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;
  logic in_acc;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_acc     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_acc && (in_data_i.operation == ermq12_pkg::OP_BUILD);
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: three copies of the table, one read port each
  logic [WW-1:0] tab_a_q [TABLE_DEPTH];
  logic [WW-1:0] tab_b_q [TABLE_DEPTH];
  logic [WW-1:0] tab_c_q [TABLE_DEPTH];
  logic [WW-1:0] word_a_q, word_b_q, word_c_q;
  logic [AW-1:0] wr_idx, rd_a, rd_b, rd_c;
  logic [WW-1:0] wr_word;
  logic          wr_en;

  assign wr_idx  = fold_idx(in_data_i.entry_index[ermq12_pkg::ANGLE_W-1:0]);
  assign rd_a    = fold_idx(in_data_i.angle_first[ermq12_pkg::ANGLE_W-1:0]);
  assign rd_b    = fold_idx(in_data_i.angle_second[ermq12_pkg::ANGLE_W-1:0]);
  assign rd_c    = fold_idx(in_data_i.angle_third[ermq12_pkg::ANGLE_W-1:0]);
  assign wr_word = {in_data_i.entry_high, in_data_i.entry_low};
  assign wr_en   = in_acc && (in_data_i.operation == ermq12_pkg::OP_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_a_q[wr_idx] <= wr_word;
      tab_b_q[wr_idx] <= wr_word;
      tab_c_q[wr_idx] <= wr_word;
    end
    if (en1) begin
      word_a_q <= tab_a_q[rd_a];
      word_b_q <= tab_b_q[rd_b];
      word_c_q <= tab_c_q[rd_c];
    end
  end

  // stage 2: first-level products
  logic signed [HW-1:0] l0, h0, l1, h1, l2, h2;
  logic signed [ermq12_pkg::PROD_W-1:0] p_l0l1, p_h0h2, p_h0l2, p_h2h1, p_l0l2;
  logic signed [ermq12_pkg::PROD_W-1:0] p_l2h1, p_l0h2, p_h1l0, p_h1h0;

  assign l0 = word_a_q[HW-1:0];
  assign h0 = word_a_q[WW-1:HW];
  assign l1 = word_b_q[HW-1:0];
  assign h1 = word_b_q[WW-1:HW];
  assign l2 = word_c_q[HW-1:0];
  assign h2 = word_c_q[WW-1:HW];

  always_comb begin
    p_l0l1 = l0 * l1;
    p_h0h2 = h0 * h2;
    p_h0l2 = h0 * l2;
    p_h2h1 = h2 * h1;
    p_l0l2 = l0 * l2;
    p_l2h1 = l2 * h1;
    p_l0h2 = l0 * h2;
    p_h1l0 = h1 * l0;
    p_h1h0 = h1 * h0;
  end

  logic signed [PW-1:0] pab_q, pac_q, p1v_q;
  logic signed [HW-1:0] l1_s2_q, l2_s2_q, h2_s2_q;
  logic signed [HW-1:0] m00_s2_q, l0l2_s2_q, m10_s2_q, l0h2_s2_q;
  logic signed [HW-1:0] m20_s2_q, m21_s2_q, m22_s2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pab_q     <= p_l0l1[ermq12_pkg::PROD_W-1:FRACTION_BITS];
      pac_q     <= p_h0h2[ermq12_pkg::PROD_W-1:FRACTION_BITS];
      p1v_q     <= p_h0l2[ermq12_pkg::PROD_W-1:FRACTION_BITS];
      l1_s2_q   <= l1;
      l2_s2_q   <= l2;
      h2_s2_q   <= h2;
      m00_s2_q  <= p_h2h1[FRACTION_BITS+HW-1:FRACTION_BITS];
      l0l2_s2_q <= p_l0l2[FRACTION_BITS+HW-1:FRACTION_BITS];
      m10_s2_q  <= p_l2h1[FRACTION_BITS+HW-1:FRACTION_BITS];
      l0h2_s2_q <= p_l0h2[FRACTION_BITS+HW-1:FRACTION_BITS];
      m20_s2_q  <= HW'(0) - l1;
      m21_s2_q  <= p_h1l0[FRACTION_BITS+HW-1:FRACTION_BITS];
      m22_s2_q  <= p_h1h0[FRACTION_BITS+HW-1:FRACTION_BITS];
    end
  end

  // stage 3: second-level products, only the bits that survive truncation
  logic signed [PW+HW-1:0] t_pab_h2, t_pac_l1, t_pab_l2, t_p1v_l1;

  always_comb begin
    t_pab_h2 = pab_q * h2_s2_q;
    t_pac_l1 = pac_q * l1_s2_q;
    t_pab_l2 = pab_q * l2_s2_q;
    t_p1v_l1 = p1v_q * l1_s2_q;
  end

  logic signed [HW-1:0] a01_q, b01_q, a02_q, b02_q, a11_q, b11_q, a12_q, b12_q;
  logic signed [HW-1:0] m00_s3_q, m10_s3_q, m20_s3_q, m21_s3_q, m22_s3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      a01_q    <= t_pab_h2[FRACTION_BITS+HW-1:FRACTION_BITS];
      b01_q    <= p1v_q[HW-1:0];
      a02_q    <= t_pac_l1[FRACTION_BITS+HW-1:FRACTION_BITS];
      b02_q    <= l0l2_s2_q;
      a11_q    <= t_pab_l2[FRACTION_BITS+HW-1:FRACTION_BITS];
      b11_q    <= pac_q[HW-1:0];
      a12_q    <= t_p1v_l1[FRACTION_BITS+HW-1:FRACTION_BITS];
      b12_q    <= l0h2_s2_q;
      m00_s3_q <= m00_s2_q;
      m10_s3_q <= m10_s2_q;
      m20_s3_q <= m20_s2_q;
      m21_s3_q <= m21_s2_q;
      m22_s3_q <= m22_s2_q;
    end
  end

  // stage 4: sums wrap to 16 bits, output register
  ermq12_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_q.m00 <= m00_s3_q;
      out_q.m01 <= a01_q - b01_q;
      out_q.m02 <= a02_q + b02_q;
      out_q.m10 <= m10_s3_q;
      out_q.m11 <= a11_q + b11_q;
      out_q.m12 <= a12_q - b12_q;
      out_q.m20 <= m20_s3_q;
      out_q.m21 <= m21_s3_q;
      out_q.m22 <= m22_s3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // a table write never enters the arithmetic stages
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en) |=> !v1_q)
    else $error("write transaction entered the pipeline");

  // a build always lands in stage 1
  a_build_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.operation == ermq12_pkg::OP_BUILD) |=> v1_q)
    else $error("build transaction lost at stage 1");

  // an empty first stage always takes a transaction
  a_ready_on_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input stalled with empty first stage");

  // a stalled middle stage keeps its item
  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> v2_q)
    else $error("stage 2 item dropped under stall");

  // a stalled result is not replaced
  a_stage4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(out_q)))
    else $error("output register changed under stall");

endmodule

// File: sim/ermq12_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ermq12_checker
// Watches both channels of the rotation matrix builder. It keeps its own copy
// of the angle table, works out each matrix when a build transaction is
// accepted, and compares every result transaction element by element.
// ----------------------------------------------------------------------------
module ermq12_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  ermq12_pkg::in_item_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  ermq12_pkg::out_item_t out_data_i,
  output int                    fail_count_o,
  output int                    matrix_pending_o
);

  localparam int DEPTH = 4096;
  localparam int FRAC  = 12;
  localparam int N_ELEM = 9;

  logic [ermq12_pkg::WORD_W-1:0] angle_words [DEPTH];
  ermq12_pkg::out_item_t         matrix_q [$];
  string                         elem_name [N_ELEM] = '{"m00", "m01", "m02", "m10", "m11",
                                                        "m12", "m20", "m21", "m22"};

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [ermq12_pkg::PROD_W-1:0] sext_half(
    input logic [ermq12_pkg::HALF_W-1:0] h);
    return {{(ermq12_pkg::PROD_W-ermq12_pkg::HALF_W){h[ermq12_pkg::HALF_W-1]}}, h};
  endfunction

  // product wraps to 32 bits, then arithmetic shift by the fraction width
  function automatic logic [ermq12_pkg::PROD_W-1:0] q_mul(
    input logic [ermq12_pkg::PROD_W-1:0] a,
    input logic [ermq12_pkg::PROD_W-1:0] b);
    logic [ermq12_pkg::PROD_W-1:0] p;
    p = a * b;
    return $unsigned($signed(p) >>> FRAC);
  endfunction

  function automatic ermq12_pkg::out_item_t rotation_of(input ermq12_pkg::in_item_t it);
    logic [ermq12_pkg::WORD_W-1:0] w0, w1, w2;
    logic [ermq12_pkg::PROD_W-1:0] l0, h0, l1, h1, l2, h2;
    logic [ermq12_pkg::PROD_W-1:0] pab, pac, phl;
    logic [ermq12_pkg::PROD_W-1:0] r [N_ELEM];
    ermq12_pkg::out_item_t         m;
    w0 = angle_words[it.angle_first[ermq12_pkg::ANGLE_W-1:0]];
    w1 = angle_words[it.angle_second[ermq12_pkg::ANGLE_W-1:0]];
    w2 = angle_words[it.angle_third[ermq12_pkg::ANGLE_W-1:0]];
    l0 = sext_half(w0[ermq12_pkg::HALF_W-1:0]);
    h0 = sext_half(w0[ermq12_pkg::WORD_W-1:ermq12_pkg::HALF_W]);
    l1 = sext_half(w1[ermq12_pkg::HALF_W-1:0]);
    h1 = sext_half(w1[ermq12_pkg::WORD_W-1:ermq12_pkg::HALF_W]);
    l2 = sext_half(w2[ermq12_pkg::HALF_W-1:0]);
    h2 = sext_half(w2[ermq12_pkg::WORD_W-1:ermq12_pkg::HALF_W]);
    pab = q_mul(l0, l1);
    pac = q_mul(h0, h2);
    phl = q_mul(h0, l2);
    r[0] = q_mul(h2, h1);
    r[1] = q_mul(pab, h2) - phl;
    r[2] = q_mul(pac, l1) + q_mul(l0, l2);
    r[3] = q_mul(l2, h1);
    r[4] = q_mul(pab, l2) + pac;
    r[5] = q_mul(phl, l1) - q_mul(l0, h2);
    r[6] = '0 - l1;
    r[7] = q_mul(h1, l0);
    r[8] = q_mul(h1, h0);
    for (int k = 0; k < N_ELEM; k++) begin
      m[ermq12_pkg::HALF_W*(N_ELEM-1-k) +: ermq12_pkg::HALF_W] =
        r[k][ermq12_pkg::HALF_W-1:0];
    end
    return m;
  endfunction

  always @(posedge clk_i) begin
    ermq12_pkg::out_item_t         want;
    logic [ermq12_pkg::HALF_W-1:0] got_e, want_e;
    if (!rst_ni) begin
      fail_count_o     = 0;
      matrix_pending_o = 0;
      matrix_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("result transaction with no matrix pending");
        end else begin
          want = matrix_q.pop_front();
          for (int k = 0; k < N_ELEM; k++) begin
            got_e  = out_data_i[ermq12_pkg::HALF_W*(N_ELEM-1-k) +: ermq12_pkg::HALF_W];
            want_e = want[ermq12_pkg::HALF_W*(N_ELEM-1-k) +: ermq12_pkg::HALF_W];
            if (got_e !== want_e) begin
              report_mismatch($sformatf("%s got %0d expected %0d", elem_name[k],
                                        $signed(got_e), $signed(want_e)));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.operation == ermq12_pkg::OP_WRITE) begin
          angle_words[in_data_i.entry_index] = {in_data_i.entry_high,
                                                in_data_i.entry_low};
        end else begin
          matrix_q.push_back(rotation_of(in_data_i));
        end
      end
      matrix_pending_o = matrix_q.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives table writes and matrix builds into the rotation matrix builder:
// a directed set of extreme entries first, then random traffic over four
// idle/stall phases. Builds only ever look up entries already written.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH = 4096;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  ermq12_pkg::in_item_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  ermq12_pkg::out_item_t out_data_o;

  int        fail_count;
  int        matrix_pending;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  logic      written_map [DEPTH];
  int        written_list [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  euler_rotation_matrix_q12 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ermq12_checker u_matrix_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .fail_count_o     (fail_count),
    .matrix_pending_o (matrix_pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_txn(input ermq12_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // half the time plausible sine/cosine magnitudes, otherwise the full range
  function automatic logic [ermq12_pkg::HALF_W-1:0] rand_half();
    if ($urandom_range(0, 1) == 0) begin
      return ermq12_pkg::HALF_W'($urandom_range(0, 65535));
    end
    return ermq12_pkg::HALF_W'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic logic [ermq12_pkg::FIELD_W-1:0] pick_angle();
    logic [ermq12_pkg::ANGLE_W-1:0] idx;
    idx = ermq12_pkg::ANGLE_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
    return {4'($urandom_range(0, 15)), idx};
  endfunction

  task automatic write_entry(input int idx, input logic [ermq12_pkg::HALF_W-1:0] lo,
                             input logic [ermq12_pkg::HALF_W-1:0] hi);
    ermq12_pkg::in_item_t it;
    it.operation    = ermq12_pkg::OP_WRITE;
    it.entry_index  = ermq12_pkg::INDEX_W'(idx);
    it.entry_low    = lo;
    it.entry_high   = hi;
    // angle fields are don't-care on a write
    it.angle_first  = ermq12_pkg::FIELD_W'($urandom_range(0, 65535));
    it.angle_second = ermq12_pkg::FIELD_W'($urandom_range(0, 65535));
    it.angle_third  = ermq12_pkg::FIELD_W'($urandom_range(0, 65535));
    send_txn(it);
    if (!written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic build_txn(input logic [ermq12_pkg::FIELD_W-1:0] a0,
                           input logic [ermq12_pkg::FIELD_W-1:0] a1,
                           input logic [ermq12_pkg::FIELD_W-1:0] a2);
    ermq12_pkg::in_item_t it;
    it.operation    = ermq12_pkg::OP_BUILD;
    it.entry_index  = ermq12_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
    it.entry_low    = ermq12_pkg::HALF_W'($urandom_range(0, 65535));
    it.entry_high   = ermq12_pkg::HALF_W'($urandom_range(0, 65535));
    it.angle_first  = a0;
    it.angle_second = a1;
    it.angle_third  = a2;
    send_txn(it);
  endtask

  initial begin
    int sender_idle [4];
    int recv_stall [4];
    sender_idle = '{0, 51, 0, 9};
    recv_stall  = '{0, 0, 51, 9};
    for (int i = 0; i < DEPTH; i++) begin
      written_map[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extreme entries: most negative / most positive halves, unit values
    write_entry(0, 16'h8000, 16'h7FFF);
    write_entry(4095, 16'h7FFF, 16'h8000);
    write_entry(1, 16'h1000, 16'h0000);
    write_entry(2, 16'h0000, 16'h1000);
    write_entry(3, 16'hF000, 16'hF000);
    write_entry(2048, 16'd2896, -16'sd2896);
    // wide products and negation of the most negative low half
    build_txn(16'h0000, 16'h0000, 16'h0000);
    build_txn(16'h0FFF, 16'h0FFF, 16'h0FFF);
    // upper angle bits must be ignored
    build_txn(16'hF000, 16'h0FFF, 16'hF000);
    build_txn(16'hFFFF, 16'h0000, 16'hAFFF);
    build_txn(16'h0001, 16'h0002, 16'h0003);
    build_txn(16'h0002, 16'h0001, 16'h0003);
    build_txn(16'h5001, 16'h3001, 16'hC001);
    build_txn(16'h0800, 16'h0001, 16'h0FFF);
    build_txn(16'h0003, 16'h0003, 16'h0003);
    // overwrite then read back in the very next transaction
    write_entry(1, 16'h0000, 16'h1000);
    build_txn(16'h0001, 16'h0001, 16'h0001);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_idle[p];
      stall_pct     = recv_stall[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          write_entry($urandom_range(0, DEPTH - 1), rand_half(), rand_half());
        end else begin
          build_txn(pick_angle(), pick_angle(), pick_angle());
        end
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    @(posedge clk_i);
    while (matrix_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: euler_rotation_matrix_q12.f
sv/ermq12_pkg.sv
sv/euler_rotation_matrix_q12.sv
sim/ermq12_checker.sv
sim/tb.sv
